// ===== sv/krm_pkg.sv =====
// Package for the keystroke rate meter: field widths, reset values,
// register indexes and the sequencer state type.
// No dependencies; every other file of the block but krm_divider imports it.
`timescale 1ns / 1ps

package krm_pkg;

  // Field widths of the request and result channels and the registers.
  localparam int TIME_W  = 32;
  localparam int SCALE_W = 16;
  localparam int RATE_W  = 24;

  // Largest reportable rate.
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // Default ring depth and register reset values.
  localparam int                 RING_DEPTH_DEF = 8;
  localparam logic [SCALE_W-1:0] RATE_SCALE_RST = 16'd12000;
  localparam logic [SCALE_W-1:0] DECAY_RST      = 16'd1000;

  // Configuration bus: two registers at byte addresses 0 and 4.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_RATE_SCALE = 1'b0;
  localparam logic REG_DECAY      = 1'b1;

  // Request codes.
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Query sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_NEWEST,
    S_CHK_IDLE,
    S_CHK_SPAN,
    S_DIV_BASE,
    S_TAPER,
    S_DIV_TAPER,
    S_OUT
  } state_e;

endpackage

// ===== sv/krm_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Standalone unit shared by both divisions of a rate query.
`timescale 1ns / 1ps

module krm_divider #(
  parameter int DVD_W = 36,
  parameter int DVS_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = (rem_sh >= {1'b0, dvs_q});

  // Control: iteration counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_sub[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/keystroke_rate_meter_core.sv =====
// Keystroke rate meter top level: timestamp ring, configuration
// registers and query sequencer. Uses krm_pkg and krm_divider.
`timescale 1ns / 1ps

//  Channel   | Signals                          | Direction
//  ----------+----------------------------------+----------
//  request   | in_valid_i, in_stall_o, mode_i,  | in
//            | time_ms_i                        |
//  result    | out_valid_o, out_stall_i, rate_o | out
//  config    | psel, penable, pwrite, paddr,    | in/out
//            | pwdata, prdata, pready           |
//
// A record request leaves the sequencer idle, so back-to-back records are fine.
// A query that gets past the idle and span checks passes twice through the
// shared one-bit-per-cycle divider.
// Reset clears the ring pointers and loads the register defaults.
// A stalled result is held in the output register; the next request is
// taken meanwhile, but a new query result waits for that register to free.

module keystroke_rate_meter_core
  import krm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [TIME_W-1:0]  time_ms_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RATE_W-1:0]  rate_o,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int NUM_W = CNT_W + SCALE_W;
  localparam int DVD_W = NUM_W + SCALE_W;

  // Configuration registers
  logic [SCALE_W-1:0] scale_q;
  logic [SCALE_W-1:0] decay_q;
  logic               cfg_wr;

  // Ring state
  logic [TIME_W-1:0]  ring_mem [RING_DEPTH];
  logic [TIME_W-1:0]  rd_data_q;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   oldest_idx;
  logic [IDX_W-1:0]   newest_idx;
  logic               ring_wr;

  // Sequencer and datapath
  state_e             state_q, state_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [SCALE_W-1:0] taper_q, taper_d;
  logic [RATE_W-1:0]  res_q, res_d;
  logic [TIME_W-1:0]  stamp_diff;
  logic [NUM_W-1:0]   base_num;
  logic [DVD_W-1:0]   taper_num;
  logic               in_accept;

  // Divider interface
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [TIME_W-1:0]  div_divisor;
  logic               div_done;
  logic [DVD_W-1:0]   div_quotient;

  // Output register
  logic               out_valid_q;
  logic [RATE_W-1:0]  rate_q;

  // Configuration writes and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= RATE_SCALE_RST;
      decay_q <= DECAY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RATE_SCALE: scale_q <= pwdata[SCALE_W-1:0];
        REG_DECAY:      decay_q <= pwdata[SCALE_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RATE_SCALE: prdata = {{(PDATA_W-SCALE_W){1'b0}}, scale_q};
      REG_DECAY:      prdata = {{(PDATA_W-SCALE_W){1'b0}}, decay_q};
      default:        prdata = '0;
    endcase
  end

  // Request handshake: only the idle sequencer takes a request.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign ring_wr    = in_accept & (mode_i == MODE_RECORD);

  // Ring positions of the oldest and newest stored stamps.
  assign oldest_idx = (count_q < CNT_W'(RING_DEPTH)) ? '0 : head_q;
  assign newest_idx = (head_q == '0) ? IDX_W'(RING_DEPTH - 1) : head_q - 1'b1;
  assign rd_addr    = (state_q == S_RD_NEWEST) ? newest_idx : oldest_idx;

  // Timestamp ring memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ring_wr) begin
      ring_mem[head_q] <= time_ms_i;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  // Arithmetic around the divider.
  assign stamp_diff = now_q - rd_data_q;
  assign base_num   = NUM_W'(count_q - 1'b1) * NUM_W'(scale_q);
  assign taper_num  = DVD_W'(div_quotient[NUM_W-1:0]) * DVD_W'(taper_q);

  krm_divider #(
    .DVD_W (DVD_W),
    .DVS_W (TIME_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // Sequencer: next state, ring pointers and divider control.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    now_d        = now_q;
    taper_d      = taper_q;
    res_d        = res_q;
    div_start    = 1'b0;
    div_dividend = DVD_W'(base_num);
    div_divisor  = stamp_diff;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          now_d = time_ms_i;
          if (mode_i == MODE_RECORD) begin
            head_d = (head_q == IDX_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
            if (count_q < CNT_W'(RING_DEPTH)) begin
              count_d = count_q + 1'b1;
            end
          end else if (count_q < CNT_W'(2)) begin
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_RD_NEWEST;
          end
        end
      end
      S_RD_NEWEST: begin
        state_d = S_CHK_IDLE;
      end
      S_CHK_IDLE: begin
        // Newest stamp is on the read port; idle at or past the window gives zero.
        if (stamp_diff >= TIME_W'(decay_q)) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          taper_d = decay_q - stamp_diff[SCALE_W-1:0];
          state_d = S_CHK_SPAN;
        end
      end
      S_CHK_SPAN: begin
        // Oldest stamp is on the read port; a zero span gives zero.
        if (stamp_diff == '0) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_BASE;
        end
      end
      S_DIV_BASE: begin
        if (div_done) begin
          state_d = S_TAPER;
        end
      end
      S_TAPER: begin
        div_start    = 1'b1;
        div_dividend = taper_num;
        div_divisor  = TIME_W'(decay_q);
        state_d      = S_DIV_TAPER;
      end
      S_DIV_TAPER: begin
        if (div_done) begin
          res_d   = (div_quotient > DVD_W'(RATE_MAX)) ? RATE_MAX
                                                      : div_quotient[RATE_W-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    taper_q <= taper_d;
    res_q   <= res_d;
  end

  // Output register: loaded when the sequencer leaves S_OUT.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
      rate_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rate_o      = rate_q;

endmodule

// ===== sv/krm_checker.sv =====
// Port-level checks for the keystroke rate meter, bound to the top level.
// Depends on krm_pkg and keystroke_rate_meter_core.
`timescale 1ns / 1ps

module krm_checker
  import krm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              mode_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [RATE_W-1:0] rate_o
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rate_o))
    else $error("stalled result changed or dropped");

  // An accepted query puts the request side into a stall.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == MODE_QUERY |=> in_stall_o)
    else $error("request taken during a query");

  // A record never produces a result.
  a_record_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == MODE_RECORD && !out_valid_o
    |=> !out_valid_o)
    else $error("result appeared after a record");

  // The request side only starts stalling right after a query was taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && mode_i == MODE_QUERY))
    else $error("stall without a query");

endmodule

bind keystroke_rate_meter_core krm_checker u_krm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .rate_o      (rate_o)
);

// ===== tb/keystroke_rate_meter_checker.sv =====
// Checker for the keystroke rate meter: watches the request, result and
// configuration channels, predicts each query's rate and compares it.
// Depends on krm_pkg for widths, register indexes and request codes.
`timescale 1ns / 1ps

module keystroke_rate_meter_checker
  import krm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               mode_i,
  input  logic [TIME_W-1:0]  time_ms_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [RATE_W-1:0]  rate_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 nonzero_o
);

  localparam int DEPTH = RING_DEPTH_DEF;

  // Shadow copy of the meter's state and registers.
  logic [TIME_W-1:0]  stamps [DEPTH];
  int unsigned        stamp_count;
  int unsigned        ring_head;
  logic [SCALE_W-1:0] rate_scale;
  logic [SCALE_W-1:0] decay_ms;

  // Rates still owed by the block, oldest first.
  logic [RATE_W-1:0]  expected_rates [$];
  logic [RATE_W-1:0]  want_rate;
  logic [SCALE_W-1:0] want_reg;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Rate the meter should report for a query at time now.
  function automatic logic [RATE_W-1:0] predict_rate(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] oldest_t;
    logic [TIME_W-1:0] newest_t;
    logic [TIME_W-1:0] idle;
    logic [TIME_W-1:0] span;
    logic [63:0]       base;
    logic [63:0]       tapered;
    if (stamp_count < 2) begin
      return '0;
    end
    oldest_t = (stamp_count < DEPTH) ? stamps[0] : stamps[ring_head];
    newest_t = stamps[(ring_head + DEPTH - 1) % DEPTH];
    idle = now - newest_t;
    if (idle >= {16'd0, decay_ms}) begin
      return '0;
    end
    span = now - oldest_t;
    if (span == '0) begin
      return '0;
    end
    base = 64'(stamp_count - 1) * 64'(rate_scale) / 64'(span);
    tapered = base * 64'({16'd0, decay_ms} - idle) / 64'(decay_ms);
    if (tapered > 64'(RATE_MAX)) begin
      tapered = 64'(RATE_MAX);
    end
    return tapered[RATE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        stamps[i] = '0;
      end
      stamp_count = 0;
      ring_head = 0;
      rate_scale = RATE_SCALE_RST;
      decay_ms = DECAY_RST;
      expected_rates.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      nonzero_o = 0;
    end else begin
      // Result side: compare against the oldest owed rate.
      if (out_valid_i && !out_stall_i) begin
        if (expected_rates.size() == 0) begin
          report_mismatch($sformatf("rate %0d with no query waiting", rate_i));
        end else begin
          want_rate = expected_rates.pop_front();
          checked_o++;
          if (want_rate != '0) begin
            nonzero_o++;
          end
          if (rate_i !== want_rate) begin
            report_mismatch($sformatf("rate %0d, expected %0d", rate_i, want_rate));
          end
        end
      end

      // Request side: queries owe a rate, records move the ring.
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == MODE_QUERY) begin
          expected_rates.push_back(predict_rate(time_ms_i));
        end else begin
          stamps[ring_head] = time_ms_i;
          ring_head = (ring_head + 1) % DEPTH;
          if (stamp_count < DEPTH) begin
            stamp_count++;
          end
        end
      end

      // Register writes update the shadow; reads are checked against it.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[PADDR_W-1:2] == REG_RATE_SCALE) begin
            rate_scale = pwdata[SCALE_W-1:0];
          end else begin
            decay_ms = pwdata[SCALE_W-1:0];
          end
        end else begin
          want_reg = (paddr[PADDR_W-1:2] == REG_RATE_SCALE) ? rate_scale : decay_ms;
          if (prdata[SCALE_W-1:0] !== want_reg) begin
            report_mismatch($sformatf("register read %0d, expected %0d",
                                      prdata[SCALE_W-1:0], want_reg));
          end
        end
      end

      pending_o = expected_rates.size();
    end
  end

endmodule

// ===== tb/keystroke_rate_meter_core_tb.sv =====
// Top of the keystroke rate meter testbench: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on krm_pkg, keystroke_rate_meter_core and keystroke_rate_meter_checker.
`timescale 1ns / 1ps

module keystroke_rate_meter_core_tb
  import krm_pkg::*;
();

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 600;
  localparam int NUM_PHASES    = 7;
  localparam int ITEMS_PHASE   = 160;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = MODE_RECORD;
  logic [TIME_W-1:0]  time_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RATE_W-1:0]  rate;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;
  int checked;
  int nonzero;
  int cycle_count = 0;
  int n_records = 0;
  int n_queries = 0;

  // Pacing knobs shared between the stimulus and the result sink.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit long_hold_req = 1'b0;
  logic [TIME_W-1:0] last_stamp = '0;

  keystroke_rate_meter_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .time_ms_i   (time_ms),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .rate_o      (rate),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  keystroke_rate_meter_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .time_ms_i    (time_ms),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .rate_i       (rate),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .nonzero_o    (nonzero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rates still owed", cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink: stalls a random number of cycles before each result (none
  // while rx_calm is set), or one long stretch on request so the block backs up.
  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (rx_calm) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one request after a random gap (none while tx_calm is set) and return once it is taken.
  task automatic send_request(input logic req_mode, input logic [TIME_W-1:0] stamp);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= req_mode;
    time_ms <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req_mode == MODE_QUERY) begin
      n_queries++;
    end else begin
      n_records++;
    end
  endtask

  // Let every owed rate arrive and the block go quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register, then read it back for the checker.
  task automatic write_reg(input logic idx, input logic [SCALE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly bursts of keystrokes and queries with an idle time inside the
  // decay window, plus zero gaps, boundary idles and random noise.
  task automatic run_random(input int n_items, input logic [SCALE_W-1:0] decay);
    int pick;
    int step_max;
    int idle_max;
    logic [TIME_W-1:0] idle;
    step_max = (decay > 4) ? int'(decay) / 4 : 1;
    idle_max = (decay > 0) ? int'(decay) - 1 : 0;
    if ($urandom_range(0, 2) == 0) begin
      last_stamp = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    end else begin
      last_stamp = $urandom();
    end
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        tx_calm = ($urandom_range(0, 4) == 0);
        rx_calm = ($urandom_range(0, 4) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        if (pick < 3) begin
          last_stamp = $urandom();
        end else if (pick >= 8) begin
          last_stamp = last_stamp + $urandom_range(1, step_max);
        end
        send_request(MODE_RECORD, last_stamp);
      end else begin
        if (pick < 58) begin
          idle = $urandom();
        end else if (pick < 64) begin
          idle = '0;
        end else if (pick < 66) begin
          idle = {16'd0, decay};
        end else if (pick < 68) begin
          idle = idle_max;
        end else begin
          idle = $urandom_range(0, idle_max);
        end
        send_request(MODE_QUERY, last_stamp + idle);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin : stimulus
    logic [SCALE_W-1:0] scales [NUM_PHASES];
    logic [SCALE_W-1:0] decays [NUM_PHASES];
    scales = '{16'd12000, 16'd65535, 16'd1, 16'd0, 16'd777, 16'd0, 16'd0};
    decays = '{16'd1000, 16'd65535, 16'd1, 16'd2000, 16'd0, 16'd0, 16'd0};
    for (int p = 5; p < NUM_PHASES; p++) begin
      scales[p] = SCALE_W'($urandom_range(1, 65535));
      decays[p] = ($urandom_range(0, 1) == 0) ? SCALE_W'($urandom_range(1, 65535))
                                              : SCALE_W'($urandom_range(1, 2000));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: empty ring, single stamp, zero span, long idle,
    // a query before the newest stamp, then a full ring across the wrap.
    send_request(MODE_QUERY, 32'd0);
    send_request(MODE_RECORD, 32'd5);
    send_request(MODE_QUERY, 32'd5);
    send_request(MODE_RECORD, 32'd5);
    send_request(MODE_QUERY, 32'd5);
    send_request(MODE_QUERY, 32'd1005);
    send_request(MODE_QUERY, 32'hFFFF_FFFF);
    for (int k = 0; k < 8; k++) begin
      send_request(MODE_RECORD, 32'hFFFF_FF00 + 32'(40 * k));
    end
    send_request(MODE_QUERY, 32'h20);
    send_request(MODE_QUERY, 32'h18 + 32'd999);
    send_request(MODE_QUERY, 32'h18 + 32'd1000);
    run_random(ITEMS_PHASE, decays[0]);

    for (int p = 1; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(REG_RATE_SCALE, scales[p]);
      write_reg(REG_DECAY, decays[p]);
      if (p == 1) begin
        // Largest scale and window: densest keystrokes, then a long
        // receiver hold while queries keep coming.
        for (int k = 0; k < 8; k++) begin
          send_request(MODE_RECORD, 32'd100 + 32'(k));
        end
        send_request(MODE_QUERY, 32'd107);
        send_request(MODE_QUERY, 32'd107 + 32'd65534);
        tx_calm = 1'b1;
        long_hold_req = 1'b1;
        for (int k = 0; k < 12; k++) begin
          send_request(MODE_QUERY, 32'd107 + 32'(50 * k));
        end
        tx_calm = 1'b0;
      end
      run_random(ITEMS_PHASE, decays[p]);
    end
    drain_results();

    $display("Sent %0d keystroke records and %0d rate queries over %0d register settings.",
             n_records, n_queries, NUM_PHASES);
    $display("Checked %0d rates (%0d nonzero), %0d mismatches.", checked, nonzero, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
